@@ rtl/hpe_pkg.sv @@
// ----------------------------------------------------------------------------
// hpe_pkg
// Shared types, constants and arithmetic helpers of the polynomial value and
// slope evaluator: fixed-point word types, saturating add, rounded product
// and saturating scale by a small integer.
// ----------------------------------------------------------------------------
package hpe_pkg;

  // Number format: signed fixed point, WORD_BITS wide, FRAC_BITS fraction bits.
  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int HI_BITS    = PROD_BITS - FRAC_BITS - WORD_BITS + 1;
  localparam int SCALE_BITS = WORD_BITS + 4;

  // Polynomial shape: up to degree five, one Horner step per slot.
  localparam int NUM_COEFS   = 6;
  localparam int NUM_SLOTS   = NUM_COEFS - 1;
  localparam int SLOT_BITS   = $clog2(NUM_SLOTS);
  localparam int STEP_STAGES = 3;
  localparam int PIPE_DEPTH  = 1 + NUM_SLOTS * STEP_STAGES;
  localparam int CNT_BITS    = $clog2(PIPE_DEPTH + 1);

  // Configuration port.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEGREE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF0  = 3'd1;

  // Degree select codes; the unused code behaves as degree five.
  localparam logic [1:0] DEG_SEL_1 = 2'd0;
  localparam logic [1:0] DEG_SEL_3 = 2'd1;
  localparam logic [1:0] DEG_SEL_5 = 2'd2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef word_t [NUM_COEFS-1:0]       coef_arr_t;

  localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});
  localparam prod_t ROUND_HALF = prod_t'(1) <<< (FRAC_BITS - 1);

  // A word with its saturation flag.
  typedef struct packed {
    word_t w;
    logic  ovf;
  } sat_word_t;

  // One sample point on its way through the Horner chains.
  typedef struct packed {
    word_t t;
    word_t val;
    word_t der;
    logic  ovf;
  } item_t;

  // After the multiply stage.
  typedef struct packed {
    item_t base;
    prod_t pv;
    prod_t pd;
  } mul_item_t;

  // After the round stage.
  typedef struct packed {
    item_t base;
    word_t rv;
    word_t rd;
  } rnd_item_t;

  // Per-slot settings; the user must keep them constant while items are in flight.
  typedef struct packed {
    word_t val_coef;
    word_t der_coef;
    logic  der_scale_ovf;
    logic  val_active;
    logic  der_active;
  } slot_ctl_t;

  // Saturating sum of two words.
  function automatic sat_word_t sat_add(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    sat_word_t r;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    r.ovf = s[WORD_BITS] ^ s[WORD_BITS-1];
    if (r.ovf) begin
      r.w = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end else begin
      r.w = word_t'(s[WORD_BITS-1:0]);
    end
    return r;
  endfunction

  // Full product to word: round to nearest, ties away from zero, saturate.
  // A negative product takes half minus one, which rounds its magnitude up.
  function automatic sat_word_t round_product(prod_t p);
    logic [PROD_BITS-1:0] s;
    logic [HI_BITS-1:0]   hi;
    sat_word_t r;
    s  = p + ROUND_HALF - prod_t'(p[PROD_BITS-1]);
    hi = s[PROD_BITS-1:FRAC_BITS+WORD_BITS-1];
    r.ovf = !((&hi) || !(|hi));
    if (r.ovf) begin
      r.w = s[PROD_BITS-1] ? WORD_MIN : WORD_MAX;
    end else begin
      r.w = word_t'(s[FRAC_BITS+WORD_BITS-1:FRAC_BITS]);
    end
    return r;
  endfunction

  // Exact integer multiple of a word by a small factor, saturated.
  function automatic sat_word_t sat_scale(word_t c, logic [2:0] k);
    logic [SCALE_BITS-1:0]  p;
    logic [SCALE_BITS-WORD_BITS:0] hi;
    sat_word_t r;
    p  = {{(SCALE_BITS-WORD_BITS){c[WORD_BITS-1]}}, c} * SCALE_BITS'(k);
    hi = p[SCALE_BITS-1:WORD_BITS-1];
    r.ovf = !((&hi) || !(|hi));
    if (r.ovf) begin
      r.w = p[SCALE_BITS-1] ? WORD_MIN : WORD_MAX;
    end else begin
      r.w = word_t'(p[WORD_BITS-1:0]);
    end
    return r;
  endfunction

endpackage

@@ rtl/hpe_init.sv @@
// ----------------------------------------------------------------------------
// hpe_init
// Entry stage: picks the leading coefficient for the selected degree and its
// scaled form as the start of the value and slope chains.
// ----------------------------------------------------------------------------
module hpe_init import hpe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] degree,
  input  coef_arr_t  coefs,
  input  logic       in_valid,
  output logic       in_ready,
  input  word_t      in_t,
  output logic       out_valid,
  input  logic       out_ready,
  output item_t      out_item
);

  logic       valid_r;
  item_t      item_r;
  item_t      item_nxt;
  word_t      lead;
  logic [2:0] lead_deg;
  sat_word_t  lead_scaled;

  // Leading coefficient and its degree.
  always_comb begin
    case (degree)
      DEG_SEL_1: begin
        lead     = coefs[1];
        lead_deg = 3'd1;
      end
      DEG_SEL_3: begin
        lead     = coefs[3];
        lead_deg = 3'd3;
      end
      default: begin
        lead     = coefs[5];
        lead_deg = 3'd5;
      end
    endcase
    lead_scaled  = sat_scale(lead, lead_deg);
    item_nxt.t   = in_t;
    item_nxt.val = lead;
    item_nxt.der = lead_scaled.w;
    item_nxt.ovf = lead_scaled.ovf;
  end

  assign in_ready = !valid_r || out_ready;

  // Stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Stage word.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

@@ rtl/hpe_step.sv @@
// ----------------------------------------------------------------------------
// hpe_step
// One Horner step for both chains, in three stages: multiply by t, round and
// saturate the product, add the coefficient with saturation. A slot that the
// selected degree does not use passes its accumulator through.
// ----------------------------------------------------------------------------
module hpe_step import hpe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  slot_ctl_t ctl,
  input  logic      in_valid,
  output logic      in_ready,
  input  item_t     in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output item_t     out_item
);

  logic      m_valid_r;
  logic      r_valid_r;
  logic      a_valid_r;
  logic      m_ready;
  logic      r_ready;
  logic      a_ready;
  mul_item_t m_r;
  mul_item_t m_nxt;
  rnd_item_t r_r;
  rnd_item_t r_nxt;
  item_t     a_r;
  item_t     a_nxt;
  sat_word_t rnd_v;
  sat_word_t rnd_d;
  sat_word_t sum_v;
  sat_word_t sum_d;

  // Each stage takes a word when it is empty or its successor moves.
  assign a_ready  = !a_valid_r || out_ready;
  assign r_ready  = !r_valid_r || a_ready;
  assign m_ready  = !m_valid_r || r_ready;
  assign in_ready = m_ready;

  // Multiply stage.
  always_comb begin
    m_nxt.base = in_item;
    m_nxt.pv   = prod_t'(in_item.t) * prod_t'(in_item.val);
    m_nxt.pd   = prod_t'(in_item.t) * prod_t'(in_item.der);
  end

  // Round stage; a product's saturation counts only where the chain is in use.
  always_comb begin
    rnd_v          = round_product(m_r.pv);
    rnd_d          = round_product(m_r.pd);
    r_nxt.base     = m_r.base;
    r_nxt.rv       = rnd_v.w;
    r_nxt.rd       = rnd_d.w;
    r_nxt.base.ovf = m_r.base.ovf
                   | (ctl.val_active & rnd_v.ovf)
                   | (ctl.der_active & rnd_d.ovf);
  end

  // Add stage.
  always_comb begin
    sum_v   = sat_add(ctl.val_coef, r_r.rv);
    sum_d   = sat_add(ctl.der_coef, r_r.rd);
    a_nxt.t = r_r.base.t;
    a_nxt.val = ctl.val_active ? sum_v.w : r_r.base.val;
    a_nxt.der = ctl.der_active ? sum_d.w : r_r.base.der;
    a_nxt.ovf = r_r.base.ovf
              | (ctl.val_active & sum_v.ovf)
              | (ctl.der_active & (sum_d.ovf | ctl.der_scale_ovf));
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      r_valid_r <= 1'b0;
      a_valid_r <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid_r <= in_valid;
      end
      if (r_ready) begin
        r_valid_r <= m_valid_r;
      end
      if (a_ready) begin
        a_valid_r <= r_valid_r;
      end
    end
  end

  // Stage words.
  always_ff @(posedge clk) begin
    if (m_ready && in_valid) begin
      m_r <= m_nxt;
    end
    if (r_ready && m_valid_r) begin
      r_r <= r_nxt;
    end
    if (a_ready && r_valid_r) begin
      a_r <= a_nxt;
    end
  end

  assign out_valid = a_valid_r;
  assign out_item  = a_r;

endmodule

@@ rtl/poly_eval_value_derivative.sv @@
// ----------------------------------------------------------------------------
// poly_eval_value_derivative
// Evaluates a degree 1, 3 or 5 polynomial and its first derivative at a
// signed fixed-point sample point by Horner's rule, with rounded products,
// saturation and an overflow flag.
//
//   channel | direction | handshake         | word
//   --------+-----------+-------------------+----------------------------------
//   in      | input     | valid / ready     | sample_point
//   out     | output    | valid / ready     | poly_value, poly_slope, overflow
//   cfg     | input     | write enable only | index, data
//
// Throughput is one word per cycle while the output does not stall. The pipeline
// has one entry stage and five Horner slots of three stages each (multiply,
// round, add), each slot with a 32 by 32 multiplier.
// Reset is synchronous; it empties the pipeline and loads degree five with all
// coefficients zero. On a stall each stage holds its word and empty stages
// upstream still fill, so input is taken while a result waits.
// ----------------------------------------------------------------------------
module poly_eval_value_derivative import hpe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  word_t                   in_sample_point,
  output logic                    out_valid,
  input  logic                    out_ready,
  output word_t                   out_poly_value,
  output word_t                   out_poly_slope,
  output logic                    out_overflow_flag,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  word_t                   cfg_wdata
);

  logic [1:0]           degree_r;
  coef_arr_t            coef_r;
  logic [SLOT_BITS-1:0] first_slot;
  logic [NUM_SLOTS:0]   chain_valid;
  logic [NUM_SLOTS:0]   chain_ready;
  item_t                chain_item [NUM_SLOTS+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEG_SEL_5;
      coef_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_DEGREE) begin
        degree_r <= cfg_wdata[1:0];
      end
      for (int i = 0; i < NUM_COEFS; i++) begin
        if (cfg_index == REG_COEF0 + CFG_IDX_BITS'(i)) begin
          coef_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // First slot in use: the chains end at the last slot for every degree.
  always_comb begin
    case (degree_r)
      DEG_SEL_1: first_slot = SLOT_BITS'(NUM_SLOTS - 1);
      DEG_SEL_3: first_slot = SLOT_BITS'(NUM_SLOTS - 3);
      default:   first_slot = '0;
    endcase
  end

  // Entry stage.
  hpe_init u_init (
    .clk       (clk),
    .rst_n     (rst_n),
    .degree    (degree_r),
    .coefs     (coef_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_t      (in_sample_point),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_item  (chain_item[0])
  );

  // Horner slots; slot k adds the coefficient of t to the power NUM_SLOTS-1-k.
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
    localparam int CI = NUM_SLOTS - 1 - k;
    slot_ctl_t ctl;
    sat_word_t der_scaled;

    always_comb begin
      der_scaled        = sat_scale(coef_r[CI], 3'(CI));
      ctl.val_coef      = coef_r[CI];
      ctl.val_active    = SLOT_BITS'(k) >= first_slot;
      ctl.der_active    = (CI != 0) && (SLOT_BITS'(k) >= first_slot);
      ctl.der_coef      = der_scaled.w;
      ctl.der_scale_ovf = der_scaled.ovf;
    end

    hpe_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_item   (chain_item[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_item  (chain_item[k+1])
    );
  end

  // Result word.
  assign chain_ready[NUM_SLOTS] = out_ready;
  assign out_valid              = chain_valid[NUM_SLOTS];
  assign out_poly_value         = chain_item[NUM_SLOTS].val;
  assign out_poly_slope         = chain_item[NUM_SLOTS].der;
  assign out_overflow_flag      = chain_item[NUM_SLOTS].ovf;

endmodule

@@ rtl/hpe_checker.sv @@
// ----------------------------------------------------------------------------
// hpe_checker
// Port-level checks of the evaluator: reset, held results, and the number of
// words in flight against the pipeline depth.
// ----------------------------------------------------------------------------
module hpe_checker import hpe_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input word_t                   out_poly_value,
  input word_t                   out_poly_slope,
  input logic                    out_overflow_flag
);

  logic                in_acc;
  logic                out_acc;
  logic [CNT_BITS-1:0] cnt_r;
  logic [CNT_BITS-1:0] cnt_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Words accepted and not yet delivered.
  always_comb begin
    case ({in_acc, out_acc})
      2'b10:   cnt_nxt = cnt_r + CNT_BITS'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_BITS'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_poly_value)
      && $stable(out_poly_slope) && $stable(out_overflow_flag))
    else $error("stalled result word changed");

  // A result needs a word in flight.
  a_out_has_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result word without accepted input");

  // Input is refused only when every stage is full and the output stalls.
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> cnt_r == CNT_BITS'(PIPE_DEPTH) && !out_ready)
    else $error("input refused with room in the pipeline");

  // Never more words in flight than stages.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_BITS'(PIPE_DEPTH))
    else $error("more words in flight than pipeline stages");

endmodule

bind poly_eval_value_derivative hpe_checker u_hpe_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression for poly_eval_value_derivative
// Programs the degree and the six coefficients, streams sample points through
// the evaluator and compares every value, slope and overflow flag with a
// fixed-point Horner predictor kept in a small scoreboard. Both handshakes idle
// at random; one long output stall backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_top;
  import hpe_pkg::*;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [1:0] DEG_SEL_SPARE = 2'd3;
  localparam int LATENCY      = 16;
  localparam int DRAIN_CYCLES = LATENCY + 4;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_WORDS  = 228;
  localparam int TIMEOUT_NS   = 400000;

  // One result word: value, slope and saturation flag.
  typedef struct {
    word_t value;
    word_t slope;
    logic  ovf;
  } poly_result_t;

  // Horner predictor for value and slope with its own register copy.
  class poly_scoreboard;
    logic [1:0]   degree_code;
    word_t        coef [NUM_COEFS];
    poly_result_t expected_q [$];
    int           errors;
    int           checked;

    function new();
      degree_code = DEG_SEL_5;
      foreach (coef[k]) coef[k] = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, word_t data);
      if (idx == REG_DEGREE) begin
        degree_code = data[1:0];
      end else if (idx >= REG_COEF0 && idx < REG_COEF0 + NUM_COEFS) begin
        coef[idx - REG_COEF0] = data;
      end
    endfunction

    // The flag is shared by reference so that nested calls all raise it.
    function longint clamp_word(longint x, ref bit ovf);
      if (x > Q_MAX) begin
        ovf = 1'b1;
        return Q_MAX;
      end
      if (x < Q_MIN) begin
        ovf = 1'b1;
        return Q_MIN;
      end
      return x;
    endfunction

    // Product shifted down by the fraction bits, rounded half away from zero.
    function longint fixed_mul(longint a, longint b, ref bit ovf);
      longint p;
      longint mag;
      longint r;
      p   = a * b;
      mag = (p < 0) ? -p : p;
      r   = (mag + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return clamp_word((p < 0) ? -r : r, ovf);
    endfunction

    function void note_sample(word_t t);
      longint c [NUM_COEFS];
      longint tv;
      longint val;
      longint der;
      int top;
      bit ovf;
      poly_result_t r;
      foreach (c[k]) c[k] = longint'(coef[k]);
      tv  = longint'(t);
      ovf = 1'b0;
      case (degree_code)
        DEG_SEL_1: top = 1;
        DEG_SEL_3: top = 3;
        default:   top = 5;
      endcase
      // Value chain.
      val = c[top];
      for (int i = top - 1; i >= 0; i--) begin
        val = clamp_word(c[i] + fixed_mul(tv, val, ovf), ovf);
      end
      // Slope chain on the scaled coefficients.
      der = clamp_word(c[top] * top, ovf);
      for (int i = top - 1; i >= 1; i--) begin
        der = clamp_word(clamp_word(c[i] * i, ovf) + fixed_mul(tv, der, ovf), ovf);
      end
      r.value = word_t'(val);
      r.slope = word_t'(der);
      r.ovf   = ovf;
      expected_q.push_back(r);
    endfunction

    function void check_result(word_t value, word_t slope, logic ovf);
      poly_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, got value %h slope %h flag %b",
                 $time, value, slope, ovf);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (value !== e.value) begin
        $display("%0t: poly_value mismatch, expected %h, got %h", $time, e.value, value);
        errors++;
      end
      if (slope !== e.slope) begin
        $display("%0t: poly_slope mismatch, expected %h, got %h", $time, e.slope, slope);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $display("%0t: overflow_flag mismatch, expected %b, got %b", $time, e.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  word_t in_sample_point = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t out_poly_value;
  word_t out_poly_slope;
  logic  out_overflow_flag;
  logic  cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  word_t cfg_wdata = '0;

  poly_scoreboard sb;
  word_t coef_plan [NUM_COEFS];
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int hold_req = 0;
  int words_sent = 0;
  int settings_loaded = 0;

  poly_eval_value_derivative DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_point  (in_sample_point),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_poly_value   (out_poly_value),
    .out_poly_slope   (out_poly_slope),
    .out_overflow_flag(out_overflow_flag),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample points that sit on rounding ties and on the edges of the range.
  function automatic word_t edge_point(int k);
    case (k)
      0:       return word_t'(32'h0000_0000);
      1:       return word_t'(32'h0000_0001);
      2:       return word_t'(32'hFFFF_FFFF);
      3:       return word_t'(32'h0000_8000);
      4:       return word_t'(32'hFFFF_8000);
      5:       return word_t'(32'h0001_0000);
      6:       return word_t'(32'hFFFF_0000);
      7:       return WORD_MAX;
      default: return WORD_MIN;
    endcase
  endfunction

  // Mostly points within plus or minus two, some anywhere, some on the edges.
  function automatic word_t rand_point();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return word_t'($urandom_range(0, 32'h4_0000)) - word_t'(32'h2_0000);
      6, 7:             return word_t'($urandom());
      8:                return edge_point($urandom_range(0, 8));
      default:          return word_t'($urandom_range(0, 32'h1_0000)) - word_t'(32'h8000);
    endcase
  endfunction

  // Mostly coefficients within plus or minus four, the rest wide or extreme.
  function automatic word_t rand_coef();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return word_t'($urandom_range(0, 32'h8_0000)) - word_t'(32'h4_0000);
      4, 5:       return word_t'($urandom());
      6:          return WORD_MAX;
      default:    return ($urandom_range(0, 1) != 0) ? WORD_MIN : word_t'(0);
    endcase
  endfunction

  // Offer one word after a random gap and hold it until it is taken.
  task automatic send_sample(word_t t);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_sample_point <= t;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_sample(t);
    words_sent++;
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, word_t data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Program the degree and all coefficients; a write to the unused index
  // goes first and must change nothing.
  task automatic load_plan(logic [1:0] deg);
    word_t data;
    write_reg(REG_UNMAPPED, word_t'($urandom()));
    data      = word_t'($urandom());
    data[1:0] = deg;
    write_reg(REG_DEGREE, data);
    for (int k = 0; k < NUM_COEFS; k++) begin
      write_reg(REG_COEF0 + CFG_IDX_BITS'(k), coef_plan[k]);
    end
    settings_loaded++;
  endtask

  // Result side: random stalls, plus one long hold when requested.
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 7);
      end
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_poly_value, out_poly_slope, out_overflow_flag);
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("poly_eval_value_derivative regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [1:0] deg;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset state: degree five, all coefficients zero.
    send_sample(edge_point(0));
    send_sample(edge_point(7));
    send_sample(edge_point(8));
    wait_idle();

    // Degree one; the higher coefficients hold garbage that must be ignored.
    coef_plan[0] = word_t'(32'h7FFF_0000);
    coef_plan[1] = word_t'(32'h0001_8000);
    for (int k = 2; k < NUM_COEFS; k++) coef_plan[k] = word_t'($urandom());
    load_plan(DEG_SEL_1);
    for (int k = 0; k < 9; k++) send_sample(edge_point(k));
    wait_idle();

    // Degree three with extreme top coefficients, so the slope scale saturates.
    coef_plan[0] = word_t'(32'hFFFF_0000);
    coef_plan[1] = word_t'(32'h0001_0000);
    coef_plan[2] = WORD_MIN;
    coef_plan[3] = WORD_MAX;
    coef_plan[4] = word_t'($urandom());
    coef_plan[5] = word_t'($urandom());
    load_plan(DEG_SEL_3);
    for (int k = 0; k < 6; k++) send_sample(edge_point(k));
    wait_idle();

    // The spare degree code behaves as degree five.
    coef_plan[0] = word_t'(32'h0000_8000);
    coef_plan[1] = word_t'(32'hFFFE_8000);
    coef_plan[2] = word_t'(32'h0002_0000);
    coef_plan[3] = word_t'(32'hFFFD_0000);
    coef_plan[4] = WORD_MAX;
    coef_plan[5] = WORD_MIN;
    load_plan(DEG_SEL_SPARE);
    for (int k = 1; k < 7; k++) send_sample(edge_point(k));
    wait_idle();

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0:       deg = DEG_SEL_1;
        1:       deg = DEG_SEL_3;
        2:       deg = DEG_SEL_5;
        default: deg = DEG_SEL_SPARE;
      endcase
      for (int k = 0; k < NUM_COEFS; k++) begin
        if (p == 6) coef_plan[k] = WORD_MAX;
        else if (p == 7) coef_plan[k] = WORD_MIN;
        else coef_plan[k] = rand_coef();
      end
      load_plan(deg);
      tx_steady = (p == 1 || p == 4);
      rx_steady = (p == 1 || p == 5);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // A long output stall while words keep coming fills the pipeline.
        if (p == 3 && i == 100) begin
          hold_req  = 90;
          tx_steady = 1'b1;
        end
        if (p == 3 && i == 148) tx_steady = 1'b0;
        if (p == 2 && i == PHASE_WORDS / 2) wait_idle();
        send_sample(rand_point());
      end
      wait_idle();
    end

    $display("Checked %0d results from %0d sample points over %0d register settings,",
             sb.checked, words_sent, settings_loaded);
    $display("covering every degree code, saturation, rounding ties and backpressure.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("poly_eval_value_derivative regression: pass");
    end else begin
      $display("poly_eval_value_derivative regression: fail");
    end
    $finish;
  end

endmodule
